@@ hw/rtl/sfml_pkg.sv @@
// Shared widths, constants and types for the spring force limiter.
// No dependencies; used by every module of the block.
package sfml_pkg;

  localparam int GAIN_W  = 12;
  localparam int MAXF_W  = 16;
  localparam int POS_W   = 20;
  localparam int FORCE_W = 17;
  localparam int MAG_W   = 23;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ROOT_W  = MAG_W;
  localparam int QUO_W   = MAXF_W;
  localparam int NUM_W   = MAG_W + MAXF_W;
  localparam int AXES    = 3;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAXF = 2'd1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd300;
  localparam logic [MAXF_W-1:0] MAXF_RESET = 16'd3300;

  // x/1000 = (x>>3)/125; 2^32/125 floored
  localparam logic [25:0] RECIP_125 = 26'd34359738;
  localparam logic [9:0]  HALF_K    = 10'd500;
  localparam logic [8:0]  DIV_125   = 9'd125;

  typedef struct packed {
    logic [AXES-1:0][MAG_W-1:0] mag;
    logic [AXES-1:0]            neg;
    logic                       lim;
  } item_t;

endpackage

@@ hw/rtl/spring_force_with_magnitude_limit_top.sv @@
// Pipeline from input transaction to output: 6 front-end stages,
// 23 square-root stages, 17 divider stages, one output register.
// Throughput: one transaction per cycle; the whole pipeline holds when the
// output is stalled. Reset clears all valid bits and loads gain 300, max 3300.
// Depends on sfml_pkg, sfml_root and sfml_div.
module spring_force_with_magnitude_limit_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // pos_x, pos_y, pos_z, ref_x, ref_y, ref_z
  input  logic [6*sfml_pkg::POS_W-1:0]      s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // force_x, force_y, force_z, zero pad
  output logic [55:0]                       m_tdata,
  // limited
  output logic                              m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfml_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfml_pkg::CFG_DAT_W-1:0]    cfg_data
);

  localparam int PW = sfml_pkg::POS_W;
  localparam int MW = sfml_pkg::MAG_W;
  localparam int FW = sfml_pkg::FORCE_W;
  localparam int AX = sfml_pkg::AXES;

  logic [sfml_pkg::GAIN_W-1:0] gain;
  logic [sfml_pkg::MAXF_W-1:0] max_force;
  logic [2*sfml_pkg::MAXF_W-1:0] max_sq;
  logic en;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= sfml_pkg::GAIN_RESET;
      max_force <= sfml_pkg::MAXF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfml_pkg::REG_GAIN: gain      <= cfg_data[sfml_pkg::GAIN_W-1:0];
        sfml_pkg::REG_MAXF: max_force <= cfg_data[sfml_pkg::MAXF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    max_sq <= max_force * max_force;
  end

  // stage 1: position error magnitude and sign
  logic              v1;
  logic [AX-1:0][PW:0] d1;
  logic [AX-1:0]     n1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AX; i++) begin
        logic [PW:0] d;
        d = {s_tdata[(i+3)*PW+PW-1], s_tdata[(i+3)*PW +: PW]}
          - {s_tdata[i*PW+PW-1], s_tdata[i*PW +: PW]};
        n1[i] <= d[PW];
        d1[i] <= d[PW] ? -d : d;
      end
    end
  end

  // stage 2: gain product plus rounding half
  logic              v2;
  logic [AX-1:0][31:0] p2;
  logic [AX-1:0]     n2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n2 <= n1;
      for (int i = 0; i < AX; i++) begin
        logic [32:0] p;
        p = gain * d1[i] + 33'(sfml_pkg::HALF_K);
        p2[i] <= p[31:0];
      end
    end
  end

  // stage 3: quotient estimate by reciprocal
  logic              v3;
  logic [AX-1:0][28:0] y3;
  logic [AX-1:0][MW-1:0] e3;
  logic [AX-1:0]     n3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n3 <= n2;
      for (int i = 0; i < AX; i++) begin
        logic [54:0] m;
        m = p2[i][31:3] * sfml_pkg::RECIP_125;
        y3[i] <= p2[i][31:3];
        e3[i] <= m[54:32];
      end
    end
  end

  // stage 4: one-step correction
  logic              v4;
  logic [AX-1:0][MW-1:0] a4;
  logic [AX-1:0]     n4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n4 <= n3;
      for (int i = 0; i < AX; i++) begin
        logic [29:0] t;
        logic [8:0]  r;
        t = e3[i] * 30'(sfml_pkg::DIV_125);
        r = y3[i][8:0] - t[8:0];
        a4[i] <= (r >= sfml_pkg::DIV_125) ? e3[i] + 1'b1 : e3[i];
      end
    end
  end

  // stage 5: squares
  logic              v5;
  logic [AX-1:0][sfml_pkg::SQ_W-1:0] s5;
  sfml_pkg::item_t   it5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it5.mag <= a4;
      it5.neg <= n4;
      it5.lim <= 1'b0;
      for (int i = 0; i < AX; i++) begin
        s5[i] <= a4[i] * a4[i];
      end
    end
  end

  // stage 6: sum and limit test
  logic              v6;
  logic [sfml_pkg::SQ_W-1:0] sq6;
  sfml_pkg::item_t   it6;
  logic [sfml_pkg::SQ_W-1:0] sum;
  assign sum = s5[0] + s5[1] + s5[2];
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq6     <= sum;
      it6.mag <= it5.mag;
      it6.neg <= it5.neg;
      it6.lim <= sum > sfml_pkg::SQ_W'(max_sq);
    end
  end

  logic                           vr;
  logic [sfml_pkg::ROOT_W-1:0]    rr;
  sfml_pkg::item_t                itr;

  sfml_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .sq        (sq6),
    .in_item   (it6),
    .out_valid (vr),
    .root      (rr),
    .out_item  (itr)
  );

  logic                                      vd;
  logic [AX-1:0][sfml_pkg::QUO_W-1:0]        qd;
  sfml_pkg::item_t                           itd;

  sfml_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vr),
    .root      (rr),
    .max_force (max_force),
    .in_item   (itr),
    .out_valid (vd),
    .quo       (qd),
    .out_item  (itd)
  );

  logic [AX-1:0][FW-1:0] fo;
  logic                  lo;
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= vd;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      lo <= itd.lim;
      for (int i = 0; i < AX; i++) begin
        logic [FW-1:0] m;
        m = itd.lim ? FW'(qd[i]) : itd.mag[i][FW-1:0];
        fo[i] <= itd.neg[i] ? -m : m;
      end
    end
  end

  assign m_tdata = {5'b0, fo[2], fo[1], fo[0]};
  assign m_tuser = lo;

`ifndef SYNTHESIS
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_limited_bound: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      ($signed(fo[0]) <= $signed({1'b0, max_force}) &&
       $signed(fo[0]) >= -$signed({1'b0, max_force}) &&
       $signed(fo[1]) <= $signed({1'b0, max_force}) &&
       $signed(fo[1]) >= -$signed({1'b0, max_force}) &&
       $signed(fo[2]) <= $signed({1'b0, max_force}) &&
       $signed(fo[2]) >= -$signed({1'b0, max_force})))
    else $error("limited force exceeds max_force");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(v6) && $stable(vr) && $stable(vd)))
    else $error("pipeline moved during stall");
`endif

endmodule

@@ hw/rtl/sfml_root.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on sfml_pkg; carries the item record alongside.
module sfml_root (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [sfml_pkg::SQ_W-1:0]      sq,
  input  sfml_pkg::item_t                in_item,
  output logic                           out_valid,
  output logic [sfml_pkg::ROOT_W-1:0]    root,
  output sfml_pkg::item_t                out_item
);

  localparam int RW = sfml_pkg::ROOT_W;
  localparam int SW = sfml_pkg::SQ_W;

  logic [RW-1:0]          vld;
  logic [SW-1:0]          rad [RW];
  logic [RW+1:0]          rem [RW];
  logic [RW-1:0]          rt  [RW];
  sfml_pkg::item_t        it  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic                  src_vld;
    logic [SW-1:0]         src_rad;
    logic [RW+1:0]         src_rem;
    logic [RW-1:0]         src_rt;
    sfml_pkg::item_t       src_it;
    logic [RW+3:0]         cur;
    logic [RW+3:0]         trial;
    logic [RW+3:0]         diff;

    if (k == 0) begin : g_first
      assign src_vld = in_valid;
      assign src_rad = sq;
      assign src_rem = '0;
      assign src_rt  = '0;
      assign src_it  = in_item;
    end else begin : g_next
      assign src_vld = vld[k-1];
      assign src_rad = rad[k-1];
      assign src_rem = rem[k-1];
      assign src_rt  = rt[k-1];
      assign src_it  = it[k-1];
    end

    always_comb begin
      cur   = {src_rem, src_rad[SW-1 -: 2]};
      trial = {2'b00, src_rt, 2'b01};
      diff  = cur - trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k] <= src_rad << 2;
        it[k]  <= src_it;
        if (cur >= trial) begin
          rem[k] <= diff[RW+1:0];
          rt[k]  <= {src_rt[RW-2:0], 1'b1};
        end else begin
          rem[k] <= cur[RW+1:0];
          rt[k]  <= {src_rt[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = rt[RW-1];
  assign out_item  = it[RW-1];

endmodule

@@ hw/rtl/sfml_div.sv @@
// Pipelined scaling divider: q = (mag*max_force + root/2) / root per axis.
// Depends on sfml_pkg; one quotient bit per stage after a multiply stage.
module sfml_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [sfml_pkg::ROOT_W-1:0]     root,
  input  logic [sfml_pkg::MAXF_W-1:0]     max_force,
  input  sfml_pkg::item_t                 in_item,
  output logic                            out_valid,
  output logic [sfml_pkg::AXES-1:0][sfml_pkg::QUO_W-1:0] quo,
  output sfml_pkg::item_t                 out_item
);

  localparam int RW = sfml_pkg::ROOT_W;
  localparam int QW = sfml_pkg::QUO_W;
  localparam int NW = sfml_pkg::NUM_W;
  localparam int AX = sfml_pkg::AXES;

  logic                        v0;
  logic [RW-1:0]               rt0;
  logic [AX-1:0][RW-1:0]       rem0;
  logic [AX-1:0][QW-1:0]       lo0;
  sfml_pkg::item_t             it0;
  logic [AX-1:0][NW-1:0]       num;

  always_comb begin
    for (int i = 0; i < AX; i++) begin
      num[i] = in_item.mag[i] * max_force + NW'(root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt0 <= root;
      it0 <= in_item;
      for (int i = 0; i < AX; i++) begin
        rem0[i] <= num[i][NW-1:QW];
        lo0[i]  <= num[i][QW-1:0];
      end
    end
  end

  logic [QW-1:0]               vld;
  logic [RW-1:0]               rt  [QW];
  logic [AX-1:0][RW-1:0]       rem [QW];
  logic [AX-1:0][QW-1:0]       lo  [QW];
  logic [AX-1:0][QW-1:0]       q   [QW];
  sfml_pkg::item_t             it  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic                  src_vld;
    logic [RW-1:0]         src_rt;
    logic [AX-1:0][RW-1:0] src_rem;
    logic [AX-1:0][QW-1:0] src_lo;
    logic [AX-1:0][QW-1:0] src_q;
    sfml_pkg::item_t       src_it;
    logic [AX-1:0][RW:0]   cur;
    logic [AX-1:0][RW:0]   diff;
    logic [AX-1:0]         take;

    if (k == 0) begin : g_first
      assign src_vld = v0;
      assign src_rt  = rt0;
      assign src_rem = rem0;
      assign src_lo  = lo0;
      assign src_q   = '0;
      assign src_it  = it0;
    end else begin : g_next
      assign src_vld = vld[k-1];
      assign src_rt  = rt[k-1];
      assign src_rem = rem[k-1];
      assign src_lo  = lo[k-1];
      assign src_q   = q[k-1];
      assign src_it  = it[k-1];
    end

    always_comb begin
      for (int i = 0; i < AX; i++) begin
        cur[i]  = {src_rem[i], src_lo[i][QW-1]};
        diff[i] = cur[i] - {1'b0, src_rt};
        take[i] = cur[i] >= {1'b0, src_rt};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt[k] <= src_rt;
        it[k] <= src_it;
        for (int i = 0; i < AX; i++) begin
          lo[k][i] <= src_lo[i] << 1;
          q[k][i]  <= {src_q[i][QW-2:0], take[i]};
          rem[k][i] <= take[i] ? diff[i][RW-1:0] : cur[i][RW-1:0];
        end
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = q[QW-1];
  assign out_item  = it[QW-1];

endmodule
